[sv/dual_mode_frame_receiver_defines.svh]
// ----------------------------------------------------------------------------
// Dual-mode frame receiver assertion macros
// Shorthand for clocked properties with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODE_FRAME_RECEIVER_DEFINES_SVH
`define DUAL_MODE_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DMFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DMFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dmfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-mode frame receiver package
// Shared codes, byte constants and transaction types.
// ----------------------------------------------------------------------------
package dmfr_pkg;

	// Framing modes held in the port-mode register
	localparam logic [1:0] MODE_LEN   = 2'd1;
	localparam logic [1:0] MODE_HDR   = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_LEN;

	// Action codes
	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_REARM = 1'b1;

	// Receiver phase codes as seen on receiver_state
	localparam logic [1:0] PHASE_HUNT    = 2'd0;
	localparam logic [1:0] PHASE_LEN     = 2'd1;
	localparam logic [1:0] PHASE_COLLECT = 2'd2;
	localparam logic [1:0] PHASE_HELD    = 2'd3;

	// Frame kind codes
	localparam logic [1:0] KIND_LEN   = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	// Byte constants
	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam logic [7:0] LEN_LIMIT   = 8'h80;
	localparam logic [7:0] HDR_SHORT   = 8'h06;
	localparam logic [7:0] HDR_LONG    = 8'h86;
	localparam logic [7:0] LEN_TRAILER = 8'd3;

	// Default fixed-header frame sizes
	localparam int SHORT_FRAME_DEF = 29;
	localparam int LONG_FRAME_DEF  = 35;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} dmfr_item_t;

	typedef struct packed {
		logic       stored;
		logic [7:0] store_index;
		logic       frame_done;
		logic [1:0] frame_kind;
		logic [6:0] frame_length;
		logic       check_ok;
		logic       length_rejected;
		logic [1:0] receiver_state;
	} dmfr_result_t;

endpackage

[sv/dmfr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-mode frame receiver core
// Receiver state registers and the single-pass per-byte update logic.
// ----------------------------------------------------------------------------
module dmfr_core #(
	parameter int SHORT_FRAME = dmfr_pkg::SHORT_FRAME_DEF,
	parameter int LONG_FRAME  = dmfr_pkg::LONG_FRAME_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  dmfr_pkg::dmfr_item_t  item,
	input  logic [1:0]            mode,
	output dmfr_pkg::dmfr_result_t result
);
	import dmfr_pkg::*;

	localparam logic [6:0] SHORT_N = 7'(SHORT_FRAME);
	localparam logic [6:0] LONG_N  = 7'(LONG_FRAME);

	typedef enum logic [1:0] {
		PH_HUNT    = PHASE_HUNT,
		PH_LEN     = PHASE_LEN,
		PH_COLLECT = PHASE_COLLECT,
		PH_HELD    = PHASE_HELD
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] wpos_q, wpos_d;
	logic [7:0] target_q, target_d;
	logic [6:0] clen_q, clen_d;
	logic [1:0] kind_q, kind_d;
	logic [7:0] xor_q, xor_d;
	logic [6:0] hdr_n;
	logic       mode_on;

	assign mode_on = (mode == MODE_LEN) || (mode == MODE_HDR);
	assign hdr_n   = (item.rx_byte == HDR_SHORT) ? SHORT_N : LONG_N;

	// Work out the next state and the result of the byte in one pass
	always_comb begin
		phase_d  = phase_q;
		wpos_d   = wpos_q;
		target_d = target_q;
		clen_d   = clen_q;
		kind_d   = kind_q;
		xor_d    = xor_q;
		result   = '0;
		if (item.action == ACT_REARM) begin
			phase_d = PH_HUNT;
		end else if (mode_on) begin
			if (phase_q == PH_COLLECT) begin
				result.stored      = 1'b1;
				result.store_index = wpos_q;
				if (wpos_q < {1'b0, clen_q}) begin
					xor_d = xor_q ^ item.rx_byte;
				end
				wpos_d = wpos_q + 8'd1;
				if (wpos_d >= target_q) begin
					phase_d             = PH_HELD;
					result.frame_done   = 1'b1;
					result.frame_kind   = kind_q;
					result.frame_length = clen_q;
					result.check_ok     = (xor_d == 8'd0);
				end
			end else if (mode == MODE_LEN) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (item.rx_byte == SYNC_BYTE) begin
							phase_d = PH_LEN;
						end
					end
					PH_LEN: begin
						if (item.rx_byte < LEN_LIMIT) begin
							clen_d   = item.rx_byte[6:0];
							target_d = item.rx_byte + LEN_TRAILER;
							wpos_d   = 8'd0;
							xor_d    = 8'd0;
							kind_d   = KIND_LEN;
							phase_d  = PH_COLLECT;
						end else begin
							result.length_rejected = 1'b1;
							phase_d = PH_HUNT;
						end
					end
					default: begin
					end
				endcase
			end else if (phase_q != PH_HELD) begin
				// Header framing; awaiting length counts as hunting here
				if ((item.rx_byte == HDR_SHORT) || (item.rx_byte == HDR_LONG)) begin
					result.stored      = 1'b1;
					result.store_index = 8'd0;
					kind_d   = (item.rx_byte == HDR_SHORT) ? KIND_SHORT : KIND_LONG;
					target_d = {1'b0, hdr_n};
					clen_d   = hdr_n;
					xor_d    = (hdr_n != 7'd0) ? item.rx_byte : 8'd0;
					wpos_d   = 8'd1;
					if (wpos_d >= target_d) begin
						phase_d             = PH_HELD;
						result.frame_done   = 1'b1;
						result.frame_kind   = kind_d;
						result.frame_length = clen_d;
						result.check_ok     = (xor_d == 8'd0);
					end else begin
						phase_d = PH_COLLECT;
					end
				end else begin
					phase_d = PH_HUNT;
				end
			end
		end
		result.receiver_state = phase_d;
	end

	// Commit the update when the byte moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			wpos_q   <= 8'd0;
			target_q <= 8'd0;
			clen_q   <= 7'd0;
			kind_q   <= KIND_LEN;
			xor_q    <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			wpos_q   <= wpos_d;
			target_q <= target_d;
			clen_q   <= clen_d;
			kind_q   <= kind_d;
			xor_q    <= xor_d;
		end
	end

endmodule

[sv/dual_mode_frame_receiver.sv]
`timescale 1ns / 1ps
// Takes one byte transaction per clock while the result channel is not stalled
// and returns one result transaction per byte; each byte is registered in the
// input register feeding the per-byte update logic and its result in the result
// register behind it. port_mode is written over its own channel, which is always
// ready, and must change only while idle.
// ----------------------------------------------------------------------------
// Dual-mode frame receiver
// Input register, receiver core and result register with valid/ready flow.
// ----------------------------------------------------------------------------
module dual_mode_frame_receiver #(
	parameter int SHORT_FRAME = dmfr_pkg::SHORT_FRAME_DEF,
	parameter int LONG_FRAME  = dmfr_pkg::LONG_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] port_mode,
	// byte input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       stored,
	output logic [7:0] store_index,
	output logic       frame_done,
	output logic [1:0] frame_kind,
	output logic [6:0] frame_length,
	output logic       check_ok,
	output logic       length_rejected,
	output logic [1:0] receiver_state
);
	import dmfr_pkg::*;

	logic         mode_q;
	logic [1:0]   port_mode_q;
	logic         valid_s1, valid_s2;
	dmfr_item_t   item_s1;
	dmfr_result_t res_s2, res_d;
	logic         advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign mode_q    = (port_mode_q == MODE_LEN) || (port_mode_q == MODE_HDR);

	// Hold the port-mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			port_mode_q <= port_mode;
		end
	end

	// Input register: take a new transaction when the current one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{action: action, rx_byte: rx_byte};
		end
	end

	dmfr_core #(
		.SHORT_FRAME(SHORT_FRAME),
		.LONG_FRAME (LONG_FRAME)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.mode   (mode_q ? port_mode_q : 2'd0),
		.result (res_d)
	);

	// Result register: hold until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid       = valid_s2;
	assign stored          = res_s2.stored;
	assign store_index     = res_s2.store_index;
	assign frame_done      = res_s2.frame_done;
	assign frame_kind      = res_s2.frame_kind;
	assign frame_length    = res_s2.frame_length;
	assign check_ok        = res_s2.check_ok;
	assign length_rejected = res_s2.length_rejected;
	assign receiver_state  = res_s2.receiver_state;

endmodule

[sv/dmfr_checker.sv]
`timescale 1ns / 1ps
`include "dual_mode_frame_receiver_defines.svh"
// ----------------------------------------------------------------------------
// Dual-mode frame receiver checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module dmfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       stored,
	input logic [7:0] store_index,
	input logic       frame_done,
	input logic [1:0] frame_kind,
	input logic [6:0] frame_length,
	input logic       check_ok,
	input logic       length_rejected,
	input logic [1:0] receiver_state
);
	import dmfr_pkg::*;

	// A stalled result transaction stays put
	`DMFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({stored, store_index, frame_done, frame_kind, frame_length, check_ok, length_rejected, receiver_state}), "result changed while stalled")

	// Frame summary fields are zero outside frame end
	`DMFR_ASSERT_NOW(a_summary_zero, clk, arst_n, out_valid && !frame_done, (frame_kind == KIND_LEN) && (frame_length == 7'd0) && !check_ok, "frame summary set without frame end")

	// A completed frame leaves the receiver held and always stores its last byte
	`DMFR_ASSERT_NOW(a_done_held, clk, arst_n, out_valid && frame_done, (receiver_state == PHASE_HELD) && stored && !length_rejected, "frame end without held phase")

	// A rejected length stores nothing and returns to hunting
	`DMFR_ASSERT_NOW(a_reject_hunt, clk, arst_n, out_valid && length_rejected, (receiver_state == PHASE_HUNT) && !stored && (store_index == 8'd0), "length reject left receiver busy")

endmodule

bind dual_mode_frame_receiver dmfr_checker u_dmfr_checker (.*);

[sim/dual_mode_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-mode frame receiver testbench
// Drives byte and rearm transactions through a directed table and then through
// randomly built frames in every port mode. A transaction-level model of the receiver
// predicts each result, which is checked field by field against the block's
// output under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dual_mode_frame_receiver_tb;
	import dmfr_pkg::*;

	localparam int SHORT_N = SHORT_FRAME_DEF;
	localparam int LONG_N  = LONG_FRAME_DEF;

	// Port modes in which received bytes are ignored
	localparam logic [1:0] MODE_IDLE_LO = 2'd0;
	localparam logic [1:0] MODE_IDLE_HI = 2'd3;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;
	localparam int SEG_ITEMS    = 25;

	// Sender gap and receiver stall percentages per traffic phase
	localparam int unsigned SEND_IDLE [4] = '{0, 88, 0, 32};
	localparam int unsigned RECV_STALL[4] = '{0, 0, 88, 32};

	typedef struct packed {
		logic         is_cfg;
		logic [1:0]   mode;
		logic         act;
		logic [7:0]   data;
		logic         typed;
		dmfr_result_t want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] port_mode = MODE_RESET;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       action = ACT_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       stored;
	logic [7:0] store_index;
	logic       frame_done;
	logic [1:0] frame_kind;
	logic [6:0] frame_length;
	logic       check_ok;
	logic       length_rejected;
	logic [1:0] receiver_state;

	// Hard-typed result carried alongside a directed transaction
	logic         item_typed = 1'b0;
	dmfr_result_t item_want = '0;

	// Receiver model state
	logic [1:0] trk_mode = MODE_RESET;
	logic [1:0] trk_phase = PHASE_HUNT;
	logic [7:0] trk_pos = '0;
	logic [7:0] trk_target = '0;
	logic [6:0] trk_chk_len = '0;
	logic [1:0] trk_kind = KIND_LEN;
	logic [7:0] trk_xor = '0;

	dmfr_result_t results_due[$];
	stim_row_t    stim_table[$];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned sent_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned frames_seen = 0;
	int unsigned frames_clean = 0;
	int unsigned rejects_seen = 0;
	int unsigned max_index = 0;
	int unsigned cycle_count = 0;

	dual_mode_frame_receiver #(
		.SHORT_FRAME(SHORT_N),
		.LONG_FRAME (LONG_N)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.port_mode      (port_mode),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.stored         (stored),
		.store_index    (store_index),
		.frame_done     (frame_done),
		.frame_kind     (frame_kind),
		.frame_length   (frame_length),
		.check_ok       (check_ok),
		.length_rejected(length_rejected),
		.receiver_state (receiver_state)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Build a result from its fields
	function automatic dmfr_result_t result_of(input logic st, input logic [7:0] idx,
			input logic done, input logic [1:0] kind, input logic [6:0] len,
			input logic ok, input logic rej, input logic [1:0] phase);
		dmfr_result_t r;
		r.stored          = st;
		r.store_index     = idx;
		r.frame_done      = done;
		r.frame_kind      = kind;
		r.frame_length    = len;
		r.check_ok        = ok;
		r.length_rejected = rej;
		r.receiver_state  = phase;
		return r;
	endfunction

	// Close the frame in progress once the write position reaches its target
	function automatic void close_frame(inout dmfr_result_t r);
		trk_phase      = PHASE_HELD;
		r.frame_done   = 1'b1;
		r.frame_kind   = trk_kind;
		r.frame_length = trk_chk_len;
		r.check_ok     = (trk_xor == 8'h00);
	endfunction

	// Advance the receiver model by one transaction and return its result
	function automatic dmfr_result_t frame_track_byte(input logic act, input logic [7:0] b);
		dmfr_result_t r;
		logic [7:0] n;
		r = '0;
		if (act == ACT_REARM) begin
			trk_phase = PHASE_HUNT;
		end else if (trk_mode == MODE_LEN || trk_mode == MODE_HDR) begin
			if (trk_phase == PHASE_COLLECT) begin
				r.stored      = 1'b1;
				r.store_index = trk_pos;
				if (trk_pos < {1'b0, trk_chk_len})
					trk_xor ^= b;
				trk_pos = trk_pos + 8'd1;
				if (trk_pos >= trk_target)
					close_frame(r);
			end else if (trk_mode == MODE_LEN) begin
				if (trk_phase == PHASE_HUNT) begin
					if (b == SYNC_BYTE)
						trk_phase = PHASE_LEN;
				end else if (trk_phase == PHASE_LEN) begin
					if (b < LEN_LIMIT) begin
						trk_chk_len = b[6:0];
						trk_target  = b + LEN_TRAILER;
						trk_pos     = '0;
						trk_xor     = '0;
						trk_kind    = KIND_LEN;
						trk_phase   = PHASE_COLLECT;
					end else begin
						r.length_rejected = 1'b1;
						trk_phase = PHASE_HUNT;
					end
				end
			end else if (trk_phase != PHASE_HELD) begin
				// Fixed-header framing: awaiting length behaves as hunting
				if (b == HDR_SHORT || b == HDR_LONG) begin
					n = (b == HDR_SHORT) ? 8'(SHORT_N & 127) : 8'(LONG_N & 127);
					r.stored      = 1'b1;
					r.store_index = '0;
					trk_kind      = (b == HDR_SHORT) ? KIND_SHORT : KIND_LONG;
					trk_target    = n;
					trk_chk_len   = n[6:0];
					trk_xor       = (n != 0) ? b : 8'h00;
					trk_pos       = 8'd1;
					if (trk_pos >= trk_target)
						close_frame(r);
					else
						trk_phase = PHASE_COLLECT;
				end else begin
					trk_phase = PHASE_HUNT;
				end
			end
		end
		r.receiver_state = trk_phase;
		return r;
	endfunction

	function automatic string show_result(input dmfr_result_t r);
		return $sformatf("stored=%0d idx=%0d done=%0d kind=%0d len=%0d ok=%0d rej=%0d state=%0d",
			r.stored, r.store_index, r.frame_done, r.frame_kind, r.frame_length,
			r.check_ok, r.length_rejected, r.receiver_state);
	endfunction

	task automatic note_mismatch(input string what, input dmfr_result_t want,
			input dmfr_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $time, what);
			$display("    expected %s", show_result(want));
			$display("    actual   %s", show_result(got));
		end
	endtask

	// Directed table rows
	function automatic void add_cfg_row(input logic [1:0] mode);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.mode = mode;
		stim_table.push_back(row);
	endfunction

	function automatic void add_byte_row(input logic act, input logic [7:0] data);
		stim_row_t row;
		row = '0;
		row.act = act;
		row.data = data;
		stim_table.push_back(row);
	endfunction

	function automatic void add_known_row(input logic act, input logic [7:0] data,
			input dmfr_result_t want);
		stim_row_t row;
		row = '0;
		row.act = act;
		row.data = data;
		row.typed = 1'b1;
		row.want = want;
		stim_table.push_back(row);
	endfunction

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send_byte(input logic act, input logic [7:0] data, input logic typed,
			input dmfr_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		rx_byte    <= data;
		item_typed <= typed;
		item_want  <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Wait for every outstanding result, then write the port mode
	task automatic write_mode(input logic [1:0] mode);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		port_mode <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Length-prefixed frame: noise, sync, length, body, held bytes, rearm
	task automatic send_len_frame(input logic [7:0] len, input bit good);
		logic [7:0] acc;
		logic [7:0] b;
		int cut;
		acc = '0;
		repeat ($urandom_range(2)) begin
			b = 8'($urandom_range(255));
			if (b == SYNC_BYTE)
				b = ~b;
			send_byte(ACT_BYTE, b, 1'b0, '0);
		end
		send_byte(ACT_BYTE, SYNC_BYTE, 1'b0, '0);
		send_byte(ACT_BYTE, len, 1'b0, '0);
		if (len >= LEN_LIMIT)
			return;
		cut = ($urandom_range(9) == 0) ? int'($urandom_range(int'(len) + 2)) : int'(len) + 3;
		for (int i = 0; i < int'(len) + 3; i++) begin
			if (i == cut) begin
				send_byte(ACT_REARM, 8'($urandom_range(255)), 1'b0, '0);
				return;
			end
			b = 8'($urandom_range(255));
			if (good && i == int'(len) - 1)
				b = acc;
			if (i < int'(len))
				acc ^= b;
			send_byte(ACT_BYTE, b, 1'b0, '0);
		end
		repeat ($urandom_range(2))
			send_byte(ACT_BYTE, 8'($urandom_range(255)), 1'b0, '0);
		send_byte(ACT_REARM, 8'($urandom_range(255)), 1'b0, '0);
	endtask

	// Fixed-header frame: noise, header, body, held bytes, rearm
	task automatic send_hdr_frame(input bit good);
		logic [7:0] acc;
		logic [7:0] b;
		logic [7:0] hdr;
		int n;
		int cut;
		hdr = $urandom_range(1) ? HDR_LONG : HDR_SHORT;
		n = (hdr == HDR_SHORT) ? SHORT_N : LONG_N;
		repeat ($urandom_range(2)) begin
			b = 8'($urandom_range(255));
			if (b == HDR_SHORT || b == HDR_LONG)
				b ^= 8'h01;
			send_byte(ACT_BYTE, b, 1'b0, '0);
		end
		acc = hdr;
		send_byte(ACT_BYTE, hdr, 1'b0, '0);
		cut = ($urandom_range(9) == 0) ? int'($urandom_range(1, n - 1)) : n;
		for (int i = 1; i < n; i++) begin
			if (i == cut) begin
				send_byte(ACT_REARM, 8'($urandom_range(255)), 1'b0, '0);
				return;
			end
			b = 8'($urandom_range(255));
			if (good && i == n - 1)
				b = acc;
			acc ^= b;
			send_byte(ACT_BYTE, b, 1'b0, '0);
		end
		repeat ($urandom_range(2))
			send_byte(ACT_BYTE, 8'($urandom_range(255)), 1'b0, '0);
		send_byte(ACT_REARM, 8'($urandom_range(255)), 1'b0, '0);
	endtask

	// Drive out_ready: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_taken) begin
			out_ready  <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			hold_taken <= hold_asks;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check results, track configuration and predict accepted transactions
	always @(posedge clk) begin : monitor
		dmfr_result_t got;
		dmfr_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = result_of(stored, store_index, frame_done, frame_kind, frame_length,
					check_ok, length_rejected, receiver_state);
				if (results_due.size() == 0) begin
					note_mismatch("result with no transaction outstanding", '0, got);
				end else begin
					want = results_due.pop_front();
					if (got.stored !== want.stored || got.store_index !== want.store_index ||
							got.frame_done !== want.frame_done ||
							got.frame_kind !== want.frame_kind ||
							got.frame_length !== want.frame_length ||
							got.check_ok !== want.check_ok ||
							got.length_rejected !== want.length_rejected ||
							got.receiver_state !== want.receiver_state)
						note_mismatch("result mismatch", want, got);
				end
				if (got.frame_done === 1'b1) begin
					frames_seen++;
					if (got.check_ok === 1'b1)
						frames_clean++;
				end
				if (got.length_rejected === 1'b1)
					rejects_seen++;
				if (got.stored === 1'b1 && got.store_index > max_index)
					max_index = got.store_index;
			end
			if (cfg_valid && cfg_ready)
				trk_mode = port_mode;
			if (in_valid && in_ready) begin
				want = frame_track_byte(action, rx_byte);
				if (item_typed)
					want = item_want;
				results_due.push_back(want);
			end
		end
	end

	// Abort a hung run
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int unsigned seg_end;
		int unsigned pick;
		logic [7:0] len;

		// Length-prefixed framing: reset state, sync, rejected lengths, empty frame
		add_cfg_row(MODE_LEN);
		add_known_row(ACT_BYTE, 8'h00, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_HUNT));
		add_known_row(ACT_BYTE, SYNC_BYTE, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_LEN));
		add_known_row(ACT_BYTE, 8'hFF, result_of(0, 0, 0, KIND_LEN, 0, 0, 1, PHASE_HUNT));
		add_byte_row(ACT_BYTE, SYNC_BYTE);
		add_known_row(ACT_BYTE, LEN_LIMIT, result_of(0, 0, 0, KIND_LEN, 0, 0, 1, PHASE_HUNT));
		add_byte_row(ACT_BYTE, SYNC_BYTE);
		add_known_row(ACT_BYTE, 8'h00, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_COLLECT));
		add_byte_row(ACT_BYTE, 8'h12);
		add_byte_row(ACT_BYTE, 8'h34);
		add_known_row(ACT_BYTE, 8'h56, result_of(1, 2, 1, KIND_LEN, 0, 1, 0, PHASE_HELD));
		// Held frame ignores bytes until rearm
		add_known_row(ACT_BYTE, SYNC_BYTE, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_HELD));
		add_known_row(ACT_REARM, 8'hFF, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_HUNT));
		// Longest length, then ignoring modes and a switch to headers mid-frame
		add_byte_row(ACT_BYTE, SYNC_BYTE);
		add_byte_row(ACT_BYTE, 8'h7F);
		add_byte_row(ACT_BYTE, 8'h00);
		add_cfg_row(MODE_IDLE_LO);
		add_known_row(ACT_BYTE, 8'h55, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_COLLECT));
		add_cfg_row(MODE_IDLE_HI);
		add_known_row(ACT_BYTE, 8'hFF, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_COLLECT));
		add_cfg_row(MODE_HDR);
		add_byte_row(ACT_BYTE, 8'h01);
		add_byte_row(ACT_REARM, 8'h00);
		// Header byte arriving while a length byte is awaited
		add_cfg_row(MODE_LEN);
		add_byte_row(ACT_BYTE, SYNC_BYTE);
		add_cfg_row(MODE_HDR);
		add_byte_row(ACT_BYTE, HDR_LONG);
		add_byte_row(ACT_BYTE, HDR_SHORT);
		add_known_row(ACT_REARM, 8'h00, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_HUNT));
		add_known_row(ACT_BYTE, 8'h07, result_of(0, 0, 0, KIND_LEN, 0, 0, 0, PHASE_HUNT));
		add_byte_row(ACT_BYTE, HDR_SHORT);
		add_byte_row(ACT_BYTE, 8'h13);
		add_byte_row(ACT_REARM, SYNC_BYTE);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg)
				write_mode(stim_table[i].mode);
			else
				send_byte(stim_table[i].act, stim_table[i].data, stim_table[i].typed,
					stim_table[i].want);
		end

		// Random framed traffic under each flow-control mix
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			stall_pct = RECV_STALL[ph];

			write_mode(MODE_LEN);
			if (ph == 0) begin
				// Hold the output off while the sender keeps offering bytes
				hold_asks++;
				send_len_frame(8'h7F, 1'b1);
			end
			seg_end = sent_count + SEG_ITEMS;
			while (sent_count < seg_end) begin
				pick = $urandom_range(99);
				if (pick < 8)
					len = 8'($urandom_range(128, 255));
				else if (pick < 14)
					len = 8'($urandom_range(9, 127));
				else
					len = 8'($urandom_range(0, 8));
				send_len_frame(len, 1'($urandom_range(1)));
			end

			write_mode(MODE_HDR);
			seg_end = sent_count + SEG_ITEMS;
			while (sent_count < seg_end)
				send_hdr_frame(1'($urandom_range(1)));

			write_mode((ph % 2 == 0) ? MODE_IDLE_LO : MODE_IDLE_HI);
			repeat (3)
				send_byte(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, '0);
		end

		// Drain and let any stray result show up
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d transactions: %0d table rows, then framed traffic in all port modes",
			sent_count, stim_table.size());
		$display("under four gap/stall mixes with a %0d-cycle output hold-off.", HOLD_CYCLES);
		$display("Frames done %0d (clean check %0d), lengths rejected %0d, top index %0d, errors %0d.",
			frames_seen, frames_clean, rejects_seen, max_index, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[dual_mode_frame_receiver.f]
+incdir+sv
sv/dmfr_pkg.sv
sv/dmfr_core.sv
sv/dual_mode_frame_receiver.sv
sv/dmfr_checker.sv
sim/dual_mode_frame_receiver_tb.sv
